@@ rtl/drgg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drgg_pkg
// Shared types and constants for the debounced rebuild request gate.
// ----------------------------------------------------------------------------
package drgg_pkg;

    localparam int ACTION_BITS  = 2;
    localparam int REASON_BITS  = 8;
    localparam int VERDICT_BITS = 3;
    localparam int CFG_BITS     = 32;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET = CFG_BITS'(1000);
    localparam logic [CFG_BITS-1:0] TIMEOUT_RESET  = CFG_BITS'(30000);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_DEBOUNCE_WINDOW = 2'd0,
        CFG_STARTUP_TIMEOUT = 2'd1
    } cfg_idx_t;

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_STARTUP_BEGIN = 2'd0,
        ACT_STARTUP_DONE  = 2'd1,
        ACT_REQUEST       = 2'd2,
        ACT_POLL          = 2'd3
    } action_t;

    typedef enum logic [VERDICT_BITS-1:0] {
        VERDICT_IDLE      = 3'd0,
        VERDICT_DEBOUNCED = 3'd1,
        VERDICT_QUEUED    = 3'd2,
        VERDICT_COALESCED = 3'd3,
        VERDICT_REBUILD   = 3'd4
    } verdict_t;

    typedef struct packed {
        verdict_t                verdict;
        logic [REASON_BITS-1:0]  reason;
        logic                    expired;
    } decision_t;

endpackage

@@ rtl/drgg_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drgg_core
// Gate state and the one-pass decision for the item in the input register.
// ----------------------------------------------------------------------------
module drgg_core #(
    parameter int TIME_BITS  = 48,
    parameter int COUNT_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              fire,
    input  drgg_pkg::action_t                 action,
    input  logic [TIME_BITS-1:0]              now,
    input  logic [drgg_pkg::REASON_BITS-1:0]  reason,
    input  logic [drgg_pkg::CFG_BITS-1:0]     debounce_window,
    input  logic [drgg_pkg::CFG_BITS-1:0]     startup_timeout,
    output drgg_pkg::decision_t               decision,
    output logic [COUNT_BITS-1:0]             count,
    output logic [TIME_BITS-1:0]              waited
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic                             starting_reg,       starting_next;
    logic [TIME_BITS-1:0]             start_time_reg,     start_time_next;
    logic                             pending_reg,        pending_next;
    logic [COUNT_BITS-1:0]            pending_count_reg,  pending_count_next;
    logic [TIME_BITS-1:0]             pending_since_reg,  pending_since_next;
    logic [drgg_pkg::REASON_BITS-1:0] pending_reason_reg, pending_reason_next;
    logic [TIME_BITS-1:0]             last_rebuild_reg,   last_rebuild_next;
    logic                             has_rebuilt_reg,    has_rebuilt_next;

    logic [TIME_BITS-1:0]  since_start;
    logic [TIME_BITS-1:0]  since_rebuild;
    logic [TIME_BITS-1:0]  since_base;
    logic [TIME_BITS-1:0]  since_first;
    logic                  blocks;
    logic                  debounced;
    logic [COUNT_BITS-1:0] count_bumped;

    assign since_start   = (now > start_time_reg) ? now - start_time_reg : '0;
    assign blocks        = starting_reg && (since_start < TIME_BITS'(startup_timeout));
    assign since_rebuild = now - last_rebuild_reg;
    assign debounced     = has_rebuilt_reg && (now >= last_rebuild_reg)
                           && (since_rebuild < TIME_BITS'(debounce_window));
    assign since_base    = pending_reg ? pending_since_reg : now;
    assign since_first   = (now > since_base) ? now - since_base : '0;
    assign count_bumped  = (pending_count_reg == COUNT_MAX) ? pending_count_reg
                           : pending_count_reg + COUNT_BITS'(1);

    always_comb
    begin
        starting_next       = starting_reg;
        start_time_next     = start_time_reg;
        pending_next        = pending_reg;
        pending_count_next  = pending_count_reg;
        pending_since_next  = pending_since_reg;
        pending_reason_next = pending_reason_reg;
        last_rebuild_next   = last_rebuild_reg;
        has_rebuilt_next    = has_rebuilt_reg;

        decision.verdict = drgg_pkg::VERDICT_IDLE;
        decision.reason  = '0;
        decision.expired = 1'b0;
        count            = '0;
        waited           = '0;

        unique case (action)
            drgg_pkg::ACT_STARTUP_BEGIN:
            begin
                starting_next   = 1'b1;
                start_time_next = now;
            end
            drgg_pkg::ACT_STARTUP_DONE:
            begin
                starting_next = 1'b0;
            end
            drgg_pkg::ACT_POLL:
            begin
                if (pending_reg && !blocks)
                begin
                    decision.verdict = drgg_pkg::VERDICT_REBUILD;
                    decision.reason  = pending_reason_reg;
                    decision.expired = starting_reg;
                    count            = (pending_count_reg == '0) ? COUNT_BITS'(1)
                                       : pending_count_reg;
                    waited           = since_first;
                    pending_next        = 1'b0;
                    pending_count_next  = '0;
                    pending_since_next  = '0;
                    pending_reason_next = '0;
                    last_rebuild_next   = now;
                    has_rebuilt_next    = 1'b1;
                end
            end
            drgg_pkg::ACT_REQUEST:
            begin
                decision.reason = reason;
                if (debounced)
                begin
                    decision.verdict = drgg_pkg::VERDICT_DEBOUNCED;
                end
                else if (blocks)
                begin
                    decision.verdict = pending_reg ? drgg_pkg::VERDICT_COALESCED
                                                   : drgg_pkg::VERDICT_QUEUED;
                    count               = count_bumped;
                    waited              = since_first;
                    pending_next        = 1'b1;
                    pending_since_next  = since_base;
                    pending_count_next  = count_bumped;
                    pending_reason_next = reason;
                end
                else
                begin
                    decision.verdict = drgg_pkg::VERDICT_REBUILD;
                    decision.expired = starting_reg;
                    count            = count_bumped;
                    waited           = since_first;
                    pending_next        = 1'b0;
                    pending_count_next  = '0;
                    pending_since_next  = '0;
                    pending_reason_next = '0;
                    last_rebuild_next   = now;
                    has_rebuilt_next    = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            starting_reg       <= 1'b0;
            start_time_reg     <= '0;
            pending_reg        <= 1'b0;
            pending_count_reg  <= '0;
            pending_since_reg  <= '0;
            pending_reason_reg <= '0;
            last_rebuild_reg   <= '0;
            has_rebuilt_reg    <= 1'b0;
        end
        else if (fire)
        begin
            starting_reg       <= starting_next;
            start_time_reg     <= start_time_next;
            pending_reg        <= pending_next;
            pending_count_reg  <= pending_count_next;
            pending_since_reg  <= pending_since_next;
            pending_reason_reg <= pending_reason_next;
            last_rebuild_reg   <= last_rebuild_next;
            has_rebuilt_reg    <= has_rebuilt_next;
        end
    end

endmodule

@@ rtl/debounced_rebuild_request_gate.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// debounced_rebuild_request_gate
// Gates rebuild requests: debounce after a rebuild, queue during startup.
// ----------------------------------------------------------------------------
// One result per event, one event per cycle unless back-pressure from the
// output stalls the input. An accepted event waits in the input register, its
// verdict is decided against the gate state in a single combinational pass,
// and the result is then written to the output register. The input side keeps
// accepting while a result waits in the output register; it stalls only when
// both registers are full. Configuration writes are always accepted.
module debounced_rebuild_request_gate #(
    parameter int TIME_BITS  = 48,
    parameter int COUNT_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [drgg_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [drgg_pkg::CFG_BITS-1:0]      cfg_data,

    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [drgg_pkg::ACTION_BITS-1:0]   action,
    input  logic [TIME_BITS-1:0]               now_ms,
    input  logic [drgg_pkg::REASON_BITS-1:0]   reason_code,

    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [drgg_pkg::VERDICT_BITS-1:0]  verdict,
    output logic [COUNT_BITS-1:0]              request_count,
    output logic [drgg_pkg::REASON_BITS-1:0]   reason_out,
    output logic [TIME_BITS-1:0]               waited,
    output logic                               startup_expired
);

    logic [drgg_pkg::CFG_BITS-1:0]     debounce_reg;
    logic [drgg_pkg::CFG_BITS-1:0]     timeout_reg;

    logic                              in_vld_reg;
    logic [drgg_pkg::ACTION_BITS-1:0]  action_reg;
    logic [TIME_BITS-1:0]              now_reg;
    logic [drgg_pkg::REASON_BITS-1:0]  reason_reg;

    logic                              out_vld_reg;
    logic [drgg_pkg::VERDICT_BITS-1:0] verdict_reg;
    logic [COUNT_BITS-1:0]             count_reg;
    logic [drgg_pkg::REASON_BITS-1:0]  reason_out_reg;
    logic [TIME_BITS-1:0]              waited_reg;
    logic                              expired_reg;

    drgg_pkg::decision_t               decision;
    logic [COUNT_BITS-1:0]             count_comb;
    logic [TIME_BITS-1:0]              waited_comb;
    logic                              advance;

    assign cfg_ready = 1'b1;
    assign advance   = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready  = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= drgg_pkg::DEBOUNCE_RESET;
            timeout_reg  <= drgg_pkg::TIMEOUT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (drgg_pkg::cfg_idx_t'(cfg_index))
                drgg_pkg::CFG_DEBOUNCE_WINDOW: debounce_reg <= cfg_data;
                drgg_pkg::CFG_STARTUP_TIMEOUT: timeout_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            action_reg <= action;
            now_reg    <= now_ms;
            reason_reg <= reason_code;
        end
    end

    drgg_core #(
        .TIME_BITS  (TIME_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .fire            (advance),
        .action          (drgg_pkg::action_t'(action_reg)),
        .now             (now_reg),
        .reason          (reason_reg),
        .debounce_window (debounce_reg),
        .startup_timeout (timeout_reg),
        .decision        (decision),
        .count           (count_comb),
        .waited          (waited_comb)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            verdict_reg    <= decision.verdict;
            count_reg      <= count_comb;
            reason_out_reg <= decision.reason;
            waited_reg     <= waited_comb;
            expired_reg    <= decision.expired;
        end
    end

    assign out_valid       = out_vld_reg;
    assign verdict         = verdict_reg;
    assign request_count   = count_reg;
    assign reason_out      = reason_out_reg;
    assign waited          = waited_reg;
    assign startup_expired = expired_reg;

endmodule
